>>> rtl/halton_radical_inverse_core_macros.svh
// ============================================================================
// Halton radical inverse core assertion macros
// Shared concurrent assertion forms used by the port checker.
// ============================================================================
`ifndef HALTON_RADICAL_INVERSE_CORE_MACROS_SVH
`define HALTON_RADICAL_INVERSE_CORE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define HRI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hri assertion failed");

// The same check, also active while reset is asserted.
`define HRI_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hri assertion failed");

`endif

>>> rtl/hri_pkg.sv
// ============================================================================
// Halton radical inverse package
// Default widths, datapath constants and the sequencer state type.
// ============================================================================
`timescale 1ns / 1ps

package hri_pkg;

   // Default field widths.
   localparam int unsigned DEF_INDEX_WIDTH   = 32;
   localparam int unsigned DEF_RADIX_WIDTH   = 8;
   localparam int unsigned DEF_FRACTION_BITS = 32;

   // Quotient bits produced per cycle by the digit divider.
   localparam int unsigned DIV_BITS = 8;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MUL_NUM,
      ST_MUL_DEN,
      ST_LONGDIV,
      ST_FINISH
   } hri_state_type;

endpackage

>>> rtl/halton_radical_inverse_core.sv
// ============================================================================
// Halton radical inverse core
// Each item carries a sample index and a radix. The core splits the index into
// base-radix digits, least significant first, mirrors them about the radix
// point and returns the value as an unsigned fraction with FRACTION_BITS
// fraction bits, truncated. An index of zero, or a radix below two, returns
// zero. One item is worked on at a time. Each digit is found in the narrow
// divider, which retires eight quotient bits per cycle, and then the shared
// multiplier scales the mirrored numerator and the denominator by the radix.
// The final exact division retires the fraction bits one at a time, and the
// result then goes to the output register once that register is free. A new
// item is accepted while the previous result still waits in the output
// register.
// ============================================================================
`timescale 1ns / 1ps

module halton_radical_inverse_core #(
   parameter int unsigned INDEX_WIDTH   = hri_pkg::DEF_INDEX_WIDTH,
   parameter int unsigned RADIX_WIDTH   = hri_pkg::DEF_RADIX_WIDTH,
   parameter int unsigned FRACTION_BITS = hri_pkg::DEF_FRACTION_BITS
) (
   input  logic clock,
   input  logic reset,

   // Request channel. tdata: sample_index, radix (from bit 0 up), zero padded.
   input  logic                                                  req_tvalid,
   output logic                                                  req_tready,
   input  logic [((INDEX_WIDTH + RADIX_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,

   // Response channel. tdata: fraction (from bit 0 up), zero padded.
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [((FRACTION_BITS + 7) / 8) * 8 - 1:0]  rsp_tdata
);

   import hri_pkg::*;

   localparam int unsigned IW      = INDEX_WIDTH;
   localparam int unsigned RW      = RADIX_WIDTH;
   localparam int unsigned FB      = FRACTION_BITS;
   localparam int unsigned RSP_W   = ((FB + 7) / 8) * 8;
   // The numerator stays below the denominator radix^digits <= index*radix.
   localparam int unsigned W       = IW + RW;
   localparam int unsigned STEPS   = (IW + DIV_BITS - 1) / DIV_BITS;
   localparam int unsigned IWP     = STEPS * DIV_BITS;
   localparam int unsigned CNT_MAX = (FB > STEPS) ? FB : STEPS;
   localparam int unsigned CNT_W   = $clog2(CNT_MAX);

   // Registers.
   hri_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IWP-1:0]   quo_ff, quo_in;
   logic [RW-1:0]    drem_ff, drem_in;
   logic [RW-1:0]    base_ff, base_in;
   logic [W-1:0]     num_ff, num_in;
   logic [W-1:0]     den_ff, den_in;
   logic [FB-1:0]    q_ff, q_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [FB-1:0]    rsp_data_ff, rsp_data_in;

   // Datapath nets.
   logic [IW-1:0]    req_index;
   logic [RW-1:0]    req_radix;
   logic [RW:0]      div_trial_c;
   logic [RW-1:0]    div_rem_c;
   logic [IWP-1:0]   div_quo_c;
   logic [W-1:0]     mul_a;
   logic [W+RW-1:0]  mul_prod;
   logic [W:0]       ld_shift;
   logic             ld_take;
   logic [W-1:0]     ld_rem;
   logic             out_free;

   // Field extraction from the request.
   assign req_index = req_tdata[IW-1:0];
   assign req_radix = req_tdata[IW+RW-1:IW];

   // Digit divider: eight restoring steps per cycle on a narrow remainder.
   always_comb begin
      div_rem_c   = drem_ff;
      div_quo_c   = quo_ff;
      div_trial_c = '0;
      for (int j = 0; j < DIV_BITS; j++) begin
         div_trial_c = {div_rem_c, div_quo_c[IWP-1]};
         div_quo_c   = {div_quo_c[IWP-2:0], 1'b0};
         if (div_trial_c >= {1'b0, base_ff}) begin
            div_rem_c    = RW'(div_trial_c - {1'b0, base_ff});
            div_quo_c[0] = 1'b1;
         end else begin
            div_rem_c = div_trial_c[RW-1:0];
         end
      end
   end

   // Shared multiplier: scales the numerator, then the denominator, by the radix.
   assign mul_a    = (state_ff == ST_MUL_NUM) ? num_ff : den_ff;
   assign mul_prod = (W + RW)'(mul_a) * (W + RW)'(base_ff);

   // One step of the final long division; the numerator register holds the remainder.
   assign ld_shift = {num_ff, 1'b0};
   assign ld_take  = (ld_shift >= {1'b0, den_ff});
   assign ld_rem   = ld_take ? W'(ld_shift - {1'b0, den_ff}) : ld_shift[W-1:0];

   // The output register can take a result when empty or being emptied.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer: next state and register updates.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      drem_in      = drem_ff;
      base_in      = base_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               base_in = req_radix;
               quo_in  = IWP'(req_index);
               drem_in = '0;
               num_in  = '0;
               den_in  = W'(1);
               cnt_in  = '0;
               if ((req_radix < RW'(2)) || (req_index == '0)) begin
                  q_in     = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end

         ST_DIVIDE: begin
            quo_in  = div_quo_c;
            drem_in = div_rem_c;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = ST_MUL_NUM;
            end
         end

         ST_MUL_NUM: begin
            num_in   = mul_prod[W-1:0] + W'(drem_ff);
            state_in = ST_MUL_DEN;
         end

         ST_MUL_DEN: begin
            den_in  = mul_prod[W-1:0];
            cnt_in  = '0;
            drem_in = '0;
            if (quo_ff == '0) begin
               state_in = ST_LONGDIV;
            end else begin
               state_in = ST_DIVIDE;
            end
         end

         ST_LONGDIV: begin
            num_in = ld_rem;
            q_in   = {q_ff[FB-2:0], ld_take};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FB - 1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_data_in  = q_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      quo_ff      <= quo_in;
      drem_ff     <= drem_in;
      base_ff     <= base_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Response outputs.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule

>>> rtl/hri_checker.sv
// ============================================================================
// Halton radical inverse port checker
// Watches the handshake ports of the core and flags sequencing slips.
// ============================================================================
`timescale 1ns / 1ps
`include "halton_radical_inverse_core_macros.svh"

module hri_checker #(
   parameter int unsigned RSP_DATA_W = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A waiting result stays offered until it is taken.
   `HRI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // A waiting result keeps its value.
   `HRI_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // An accepted item occupies the core, and its result cannot appear at once.
   `HRI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready && !$rose(rsp_tvalid))

   // Reset leaves the core empty and ready for an item.
   `HRI_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind halton_radical_inverse_core hri_checker #(
   .RSP_DATA_W ($bits(rsp_tdata))
) u_hri_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
